### sv/assert_macros.svh
// Assertion macros used by the checker file of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define APQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("apq check failed");

// Check a property on every clock edge, reset included.
`define APQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("apq check failed");

`endif

### sv/apq_pkg.sv
// Types and codes of the aging priority queue.
`default_nettype none
package apq_pkg;

  // Operation codes of an input word
  typedef enum logic [1:0] {
    MODE_ARRIVE = 2'd0,
    MODE_SERVE  = 2'd1,
    MODE_DEPART = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  // Result status codes
  localparam logic [2:0] ST_SERVED   = 3'd0;
  localparam logic [2:0] ST_EMPTY    = 3'd1;
  localparam logic [2:0] ST_QUEUED   = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_DEPARTED = 3'd4;
  localparam logic [2:0] ST_DEP_FULL = 3'd5;

  // Controller states
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DSCAN = 6'b000100,
    S_ESCAN = 6'b001000,
    S_DRAIN = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  // One queue slot: doomed marks a name that had departed when it arrived
  typedef struct packed {
    logic        valid;
    logic        doomed;
    logic [63:0] prio;
    logic [63:0] name;
  } entry_t;

endpackage
`default_nettype wire

### sv/aging_priority_queue_with_cancel.sv
// Aging priority queue top level: queue table, departed store and controller.
//
// Arrivals and departures first scan the departed store, one recorded name at a
// time, when it holds any names; every word but a no-op then scans the queue
// table, one slot at a time over all QUEUE_DEPTH slots, and ends in a drain
// and a finish state, paced by the single read port of each memory. After reset
// a clearing pass sweeps every slot of the queue table; input words are stalled
// during it, configuration writes are not. A finished result sits in an output
// register, so the next word may be taken while it waits. Priority is severity -
// aging_rate * arrival_time, compared as a signed 64-bit value; ties go to the
// smaller name, then the lower slot.
`default_nettype none
module aging_priority_queue_with_cancel #(
  parameter int QUEUE_DEPTH    = 64,
  parameter int DEPARTED_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [31:0] arrival_time_i,
  input  wire logic [31:0] severity_i,
  input  wire logic [63:0] name_key_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [2:0]  status_o,
  output logic      [63:0] served_name_o
);

  localparam int QAW = $clog2(QUEUE_DEPTH);
  localparam int DAW = (DEPARTED_DEPTH > 1) ? $clog2(DEPARTED_DEPTH) : 1;
  localparam int DCW = $clog2(DEPARTED_DEPTH + 1);
  localparam logic [QAW-1:0] QLAST = QAW'(QUEUE_DEPTH - 1);
  localparam logic [DCW-1:0] DFULL = DCW'(DEPARTED_DEPTH);

  apq_pkg::state_e state_q, state_d;
  logic [23:0]      rate_q;
  apq_pkg::mode_e   mode_q;
  logic [31:0]      time_q, sev_q;
  logic [63:0]      name_q;
  logic [55:0]      prod_q;
  logic [QAW-1:0]   escan_q;
  logic [DAW-1:0]   dscan_q;
  logic [DCW-1:0]   dcnt_q;

  apq_pkg::entry_t  ent_rd_q;
  logic             ent_vld_q;
  logic [QAW-1:0]   ent_ix_q;
  logic [63:0]      dep_rd_q;
  logic             dep_vld_q;

  logic             hit_q, free_found_q, best_found_q;
  logic [QAW-1:0]   free_ix_q, best_ix_q;
  logic [63:0]      best_prio_q, best_name_q;

  logic             out_valid_q;
  logic [2:0]       status_q;
  logic [63:0]      served_q;

  apq_pkg::entry_t  ent_mem [QUEUE_DEPTH];
  logic [63:0]      dep_mem [DEPARTED_DEPTH];

  logic             in_acc, fin_go, better, dscan_last;
  logic             ent_we, dep_we;
  logic [QAW-1:0]   ent_wa;
  apq_pkg::entry_t  ent_wd;
  logic [63:0]      prio;
  logic [2:0]       status_d;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == 2'b00) ? {8'b0, rate_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
    end else if (psel && penable && pwrite && paddr == 2'b00) begin
      rate_q <= pwdata[23:0];
    end
  end

  // Handshake
  assign in_stall_o  = (state_q != apq_pkg::S_IDLE);
  assign in_acc      = in_valid_i && (state_q == apq_pkg::S_IDLE);
  assign fin_go      = (state_q == apq_pkg::S_FIN) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign served_name_o = served_q;
  assign dscan_last  = (DCW'(dscan_q) + DCW'(1)) == dcnt_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      apq_pkg::S_CLEAR: if (escan_q == QLAST) state_d = apq_pkg::S_IDLE;
      apq_pkg::S_IDLE: begin
        if (in_acc) begin
          case (apq_pkg::mode_e'(mode_i))
            apq_pkg::MODE_ARRIVE, apq_pkg::MODE_DEPART: begin
              state_d = (dcnt_q != '0) ? apq_pkg::S_DSCAN : apq_pkg::S_ESCAN;
            end
            apq_pkg::MODE_SERVE: state_d = apq_pkg::S_ESCAN;
            default: state_d = apq_pkg::S_FIN;
          endcase
        end
      end
      apq_pkg::S_DSCAN: if (dscan_last) state_d = apq_pkg::S_ESCAN;
      apq_pkg::S_ESCAN: if (escan_q == QLAST) state_d = apq_pkg::S_DRAIN;
      apq_pkg::S_DRAIN: state_d = apq_pkg::S_FIN;
      apq_pkg::S_FIN:   if (fin_go) state_d = apq_pkg::S_IDLE;
      default:          state_d = apq_pkg::S_IDLE;
    endcase
  end

  // Compare a returned slot with the best one so far
  assign better = !best_found_q ||
                  ($signed(ent_rd_q.prio) > $signed(best_prio_q)) ||
                  ((ent_rd_q.prio == best_prio_q) && (ent_rd_q.name < best_name_q));

  assign prio = {32'b0, sev_q} - {8'b0, prod_q};

  // Queue table write port
  always_comb begin
    ent_we = 1'b0;
    ent_wa = ent_ix_q;
    ent_wd = ent_rd_q;
    ent_wd.valid = 1'b0;
    if (state_q == apq_pkg::S_CLEAR) begin
      ent_we = 1'b1;
      ent_wa = escan_q;
      ent_wd = '0;
    end else if (ent_vld_q && ent_rd_q.valid) begin
      // drop doomed slots on serve, matching names on departure
      if (mode_q == apq_pkg::MODE_SERVE && ent_rd_q.doomed) ent_we = 1'b1;
      if (mode_q == apq_pkg::MODE_DEPART && ent_rd_q.name == name_q) ent_we = 1'b1;
    end else if (fin_go) begin
      if (mode_q == apq_pkg::MODE_ARRIVE && free_found_q) begin
        ent_we = 1'b1;
        ent_wa = free_ix_q;
        ent_wd = '{valid: 1'b1, doomed: hit_q, prio: prio, name: name_q};
      end else if (mode_q == apq_pkg::MODE_SERVE && best_found_q) begin
        ent_we = 1'b1;
        ent_wa = best_ix_q;
        ent_wd = '0;
      end
    end
  end

  assign dep_we = fin_go && (mode_q == apq_pkg::MODE_DEPART) && !hit_q && (dcnt_q != DFULL);

  // Result status
  always_comb begin
    case (mode_q)
      apq_pkg::MODE_ARRIVE: status_d = free_found_q ? apq_pkg::ST_QUEUED : apq_pkg::ST_FULL;
      apq_pkg::MODE_SERVE:  status_d = best_found_q ? apq_pkg::ST_SERVED : apq_pkg::ST_EMPTY;
      apq_pkg::MODE_DEPART: begin
        status_d = (hit_q || dcnt_q != DFULL) ? apq_pkg::ST_DEPARTED : apq_pkg::ST_DEP_FULL;
      end
      default: status_d = apq_pkg::ST_EMPTY;
    endcase
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (ent_we) ent_mem[ent_wa] <= ent_wd;
    ent_rd_q <= ent_mem[escan_q];
  end

  always_ff @(posedge clk_i) begin
    if (dep_we) dep_mem[dcnt_q[DAW-1:0]] <= name_q;
    dep_rd_q <= dep_mem[dscan_q];
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apq_pkg::S_CLEAR;
      escan_q     <= '0;
      dscan_q     <= '0;
      dcnt_q      <= '0;
      ent_vld_q   <= 1'b0;
      dep_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      ent_vld_q <= (state_q == apq_pkg::S_ESCAN);
      dep_vld_q <= (state_q == apq_pkg::S_DSCAN);
      // advance scan counters
      if (state_q == apq_pkg::S_CLEAR || state_q == apq_pkg::S_ESCAN) begin
        escan_q <= (escan_q == QLAST) ? '0 : escan_q + QAW'(1);
      end
      if (state_q == apq_pkg::S_DSCAN) begin
        dscan_q <= dscan_last ? '0 : dscan_q + DAW'(1);
      end
      if (dep_we) dcnt_q <= dcnt_q + DCW'(1);
      // hold the result until taken
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Word registers and scan results
  always_ff @(posedge clk_i) begin
    ent_ix_q <= escan_q;
    prod_q   <= rate_q * time_q;
    if (in_acc) begin
      mode_q       <= apq_pkg::mode_e'(mode_i);
      time_q       <= arrival_time_i;
      sev_q        <= severity_i;
      name_q       <= name_key_i;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
    end else begin
      if (dep_vld_q && dep_rd_q == name_q) hit_q <= 1'b1;
      if (ent_vld_q) begin
        if (mode_q == apq_pkg::MODE_ARRIVE && !ent_rd_q.valid && !free_found_q) begin
          free_found_q <= 1'b1;
          free_ix_q    <= ent_ix_q;
        end
        if (mode_q == apq_pkg::MODE_SERVE && ent_rd_q.valid && !ent_rd_q.doomed && better) begin
          best_found_q <= 1'b1;
          best_ix_q    <= ent_ix_q;
          best_prio_q  <= ent_rd_q.prio;
          best_name_q  <= ent_rd_q.name;
        end
      end
    end
    if (fin_go) begin
      status_q <= status_d;
      served_q <= (mode_q == apq_pkg::MODE_SERVE && best_found_q) ? best_name_q : 64'b0;
    end
  end

endmodule
`default_nettype wire

### sv/apq_checker.sv
// Port-level checks of the aging priority queue, bound to its top level.
`default_nettype none
`include "assert_macros.svh"
module apq_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  status_o,
  input wire logic [63:0] served_name_o
);

  // A stalled result word stays
  `APQ_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(served_name_o))
  // Status stays within its codes
  `APQ_ASSERT(a_status_range, out_valid_o |-> status_o <= apq_pkg::ST_DEP_FULL)
  // Only a served word carries a name
  `APQ_ASSERT(a_name_zero, out_valid_o && status_o != apq_pkg::ST_SERVED |-> served_name_o == 64'd0)
  // The register port never waits
  `APQ_ASSERT_ALWAYS(a_pready, pready)

endmodule

bind aging_priority_queue_with_cancel apq_checker u_apq_checker (.*);
`default_nettype wire
